>>> rtl/twlbt_pkg.sv
// Shared constants for the two-wire link byte transfer block.
package twlbt_pkg;

   // Word length of one transfer and the width of its bit counter
   localparam int BITS_PER_WORD  = 8;
   localparam int BIT_IDX_W      = 4;

   // Widths of the item fields and registers
   localparam int OP_W           = 2;
   localparam int LINES_W        = 2;
   localparam int BYTE_W         = 8;
   localparam int STATUS_W       = 2;
   localparam int TICK_W         = 16;
   localparam int CSR_INDEX_W    = 2;
   localparam int PHASE_W        = 3;

   // Operation codes
   localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
   localparam logic [OP_W-1:0] OP_SEND      = 2'd1;
   localparam logic [OP_W-1:0] OP_RECEIVE   = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR_ERR = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_NONE       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TX_TIMEOUT = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RX_TIMEOUT = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SEND_LIMIT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECEIVE_LIMIT = 2'd1;

   // Reset values of the limits
   localparam logic [TICK_W-1:0] SEND_LIMIT_RESET    = 16'd250;
   localparam logic [TICK_W-1:0] RECEIVE_LIMIT_RESET = 16'd1000;

   // Line patterns
   localparam logic [LINES_W-1:0] LINES_LOW      = 2'd0;
   localparam logic [LINES_W-1:0] LINES_FIRST    = 2'd1;
   localparam logic [LINES_W-1:0] LINES_SECOND   = 2'd2;
   localparam logic [LINES_W-1:0] LINES_RELEASED = 2'd3;

   // Transfer phases
   localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_S_LOW  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_S_HIGH = 3'd2;
   localparam logic [PHASE_W-1:0] PH_R_DATA = 3'd3;
   localparam logic [PHASE_W-1:0] PH_R_ACK  = 3'd4;

endpackage

>>> rtl/two_wire_link_byte_transfer_top.sv
// Two-wire handshake link: one byte per transfer, one line sample per item.
//
// Usage:
//  - Request channel (req_*): each accepted item is one sampling tick of the
//    two lines (req_lines_in) and carries an op: tick only, start send of
//    req_send_byte, start receive, or clear the sticky receive error.
//  - Response channel (rsp_*): exactly one item per request item, giving the
//    drive pattern, busy flag, received byte, status and error flag as they
//    stand after that tick.
//  - Configuration port (csr_*): send and receive tick limits, to be written only
//    while the block is idle; the block itself does not enforce this.
//  - Each response appears in the cycle after its request is accepted; one item
//    is taken every cycle while req_stall is low. The whole tick is evaluated
//    by the phase logic in front of the response register.
//  - The response register is also the skid stage: while it holds an item
//    that the receiver stalls, req_stall is raised and the phase state holds.
//  - Reset (synchronous) returns to idle with both lines released, clears the
//    error flag and the response register, and restores the default limits.
module two_wire_link_byte_transfer_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [twlbt_pkg::OP_W-1:0]            req_op,
   input  logic [twlbt_pkg::BYTE_W-1:0]          req_send_byte,
   input  logic [twlbt_pkg::LINES_W-1:0]         req_lines_in,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [twlbt_pkg::LINES_W-1:0]         rsp_lines_out,
   output logic                                  rsp_busy_res,
   output logic [twlbt_pkg::BYTE_W-1:0]          rsp_received_byte,
   output logic [twlbt_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                  rsp_error_flag,
   // configuration port
   input  logic                                  csr_write_enable,
   input  logic [twlbt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [twlbt_pkg::TICK_W-1:0]          csr_write_data
);
   import twlbt_pkg::*;

   // Configuration registers
   logic [TICK_W-1:0]    send_limit_ff;
   logic [TICK_W-1:0]    receive_limit_ff;

   // Transfer state
   logic [PHASE_W-1:0]   phase_ff,   phase_in;
   logic [BIT_IDX_W-1:0] bit_idx_ff, bit_idx_in;
   logic [BYTE_W-1:0]    shift_ff,   shift_in;
   logic [TICK_W-1:0]    elapsed_ff, elapsed_in;
   logic [LINES_W-1:0]   drive_ff,   drive_in;
   logic [LINES_W-1:0]   await_ff,   await_in;
   logic                 error_ff,   error_in;

   // Response register
   logic                 rsp_valid_ff;
   logic [BYTE_W-1:0]    rx_out_ff,  rx_out_in;
   logic [STATUS_W-1:0]  status_ff,  status_in;

   logic                 accept;
   logic                 sending;
   logic                 met;
   logic [BIT_IDX_W:0]   bit_next;
   logic                 word_done;
   logic [TICK_W-1:0]    limit;

   // Handshake: the response register parts the two channels
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign sending   = (phase_ff inside {PH_S_LOW, PH_S_HIGH});
   assign bit_next  = {1'b0, bit_idx_ff} + 1'b1;
   assign word_done = (bit_next >= (BIT_IDX_W+1)'(BITS_PER_WORD));
   assign limit     = sending ? send_limit_ff : receive_limit_ff;

   // One tick of the link
   always_comb begin
      phase_in   = phase_ff;
      bit_idx_in = bit_idx_ff;
      shift_in   = shift_ff;
      elapsed_in = elapsed_ff;
      drive_in   = drive_ff;
      await_in   = await_ff;
      error_in   = error_ff;
      status_in  = STATUS_NONE;
      rx_out_in  = '0;
      met        = 1'b0;

      if (req_op == OP_CLEAR_ERR) begin
         error_in = 1'b0;
      end

      if (phase_ff == PH_IDLE) begin
         if (req_op == OP_SEND && !error_in) begin
            shift_in   = req_send_byte;
            bit_idx_in = '0;
            elapsed_in = '0;
            drive_in   = req_send_byte[0] ? LINES_SECOND : LINES_FIRST;
            phase_in   = PH_S_LOW;
         end else if (req_op == OP_RECEIVE) begin
            shift_in   = '0;
            bit_idx_in = '0;
            elapsed_in = '0;
            phase_in   = PH_R_DATA;
         end
      end else begin
         case (phase_ff)
            PH_S_LOW: begin
               if (req_lines_in == LINES_LOW) begin
                  met      = 1'b1;
                  drive_in = LINES_RELEASED;
                  phase_in = PH_S_HIGH;
               end
            end
            PH_S_HIGH: begin
               if (req_lines_in == LINES_RELEASED) begin
                  met        = 1'b1;
                  shift_in   = shift_ff >> 1;
                  bit_idx_in = bit_next[BIT_IDX_W-1:0];
                  if (word_done) begin
                     status_in = STATUS_DONE;
                     phase_in  = PH_IDLE;
                  end else begin
                     drive_in = shift_ff[1] ? LINES_SECOND : LINES_FIRST;
                     phase_in = PH_S_LOW;
                  end
               end
            end
            PH_R_DATA: begin
               if (req_lines_in != LINES_RELEASED) begin
                  met = 1'b1;
                  if (req_lines_in == LINES_FIRST) begin
                     // one bit; bits past the byte are dropped
                     if (bit_idx_ff < BIT_IDX_W'(BYTE_W)) begin
                        shift_in[bit_idx_ff[$clog2(BYTE_W)-1:0]] = 1'b1;
                     end
                     drive_in = LINES_FIRST;
                     await_in = LINES_SECOND;
                  end else begin
                     drive_in = LINES_SECOND;
                     await_in = LINES_FIRST;
                  end
                  phase_in = PH_R_ACK;
               end
            end
            default: begin
               if ((req_lines_in & await_ff) != '0) begin
                  met        = 1'b1;
                  drive_in   = LINES_RELEASED;
                  bit_idx_in = bit_next[BIT_IDX_W-1:0];
                  if (word_done) begin
                     status_in = STATUS_DONE;
                     rx_out_in = shift_ff;
                     phase_in  = PH_IDLE;
                  end else begin
                     phase_in = PH_R_DATA;
                  end
               end
            end
         endcase

         // tick budget: time out or count on
         if (!met) begin
            if (elapsed_ff >= limit) begin
               phase_in = PH_IDLE;
               if (sending) begin
                  status_in = STATUS_TX_TIMEOUT;
               end else begin
                  status_in = STATUS_RX_TIMEOUT;
                  error_in  = 1'b1;
               end
            end else begin
               elapsed_in = elapsed_ff + 1'b1;
            end
         end
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         send_limit_ff    <= SEND_LIMIT_RESET;
         receive_limit_ff <= RECEIVE_LIMIT_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_SEND_LIMIT) begin
            send_limit_ff <= csr_write_data;
         end else if (csr_index == CSR_RECEIVE_LIMIT) begin
            receive_limit_ff <= csr_write_data;
         end
      end
   end

   // Transfer state, advanced once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         bit_idx_ff <= '0;
         shift_ff   <= '0;
         elapsed_ff <= '0;
         drive_ff   <= LINES_RELEASED;
         await_ff   <= '0;
         error_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         bit_idx_ff <= bit_idx_in;
         shift_ff   <= shift_in;
         elapsed_ff <= elapsed_in;
         drive_ff   <= drive_in;
         await_ff   <= await_in;
         error_ff   <= error_in;
      end
   end

   // Response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_out_ff <= '0;
         status_ff <= STATUS_NONE;
      end else if (accept) begin
         rx_out_ff <= rx_out_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_lines_out     = drive_ff;
   assign rsp_busy_res      = (phase_ff != PH_IDLE);
   assign rsp_received_byte = rx_out_ff;
   assign rsp_status        = status_ff;
   assign rsp_error_flag    = error_ff;

`ifndef SYNTHESIS
   // A receive timeout always leaves the sticky error set
   a_rx_timeout_sets_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == STATUS_RX_TIMEOUT) |-> error_ff)
      else $error("receive timeout without error flag");

   // A received byte is only shown with a completed transfer
   a_rx_byte_only_when_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rx_out_ff != '0) |-> (status_ff == STATUS_DONE))
      else $error("received byte shown without done status");

   // While a transfer runs, the bit counter stays inside the word
   a_bit_index_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> ({1'b0, bit_idx_ff} < (BIT_IDX_W+1)'(BITS_PER_WORD)))
      else $error("bit index past word length");

   // While a response is held, the link state does not move
   a_state_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> ($stable(phase_ff) && $stable(elapsed_ff)))
      else $error("link state moved while response held");

   // A finished transfer leaves the block idle
   a_done_is_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && status_in != STATUS_NONE) |=> (phase_ff == PH_IDLE))
      else $error("block busy after end of transfer");
`endif

endmodule
